// ===== hdl/texture_tile_swizzle_unit_assert.svh =====
// assertion macros for the texture tile swizzle unit
// included by the checker; needs clk_i and rst_ni in the including scope
`ifndef TEXTURE_TILE_SWIZZLE_UNIT_ASSERT_SVH
`define TEXTURE_TILE_SWIZZLE_UNIT_ASSERT_SVH

// implication checked on every clock edge outside reset
`define TSW_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// signal keeps its value in the cycle after the condition holds
`define TSW_ASSERT_STABLE(label, cond, sig, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== hdl/tsw_pkg.sv =====
// shared types and constants of the texture tile swizzle unit
// no dependencies
package tsw_pkg;

  // field widths
  localparam int PIX_W    = 10;
  localparam int VALUE_W  = 32;
  localparam int FMT_W    = 4;
  localparam int DIM_REG_W = 11;
  localparam int OFF_W    = 22;
  localparam int DATA_W   = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP   = 2'd3;

  // texture format codes
  localparam logic [FMT_W-1:0] FMT_I4    = 4'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8 = 4'd3;
  localparam logic [FMT_W-1:0] FMT_I8    = 4'd4;
  localparam logic [FMT_W-1:0] FMT_IA4   = 4'd6;
  localparam logic [FMT_W-1:0] FMT_C8    = 4'd8;

  // reset values of the registers
  localparam logic [FMT_W-1:0]     FORMAT_RST = 4'd0;
  localparam logic [DIM_REG_W-1:0] DIM_RST    = 11'd4;

  localparam int MAX_DIM_DEF = 1024;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
    logic [VALUE_W-1:0] pixel_value;
  } pixel_in_t;

  typedef struct packed {
    logic [OFF_W-1:0]  byte_offset;
    logic [DATA_W-1:0] write_data;
    logic              is_halfword;
    logic              coord_error;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [FMT_W-1:0]     format_code;
    logic [DIM_REG_W-1:0] image_width;
    logic [DIM_REG_W-1:0] image_height;
    logic                 endian_swap;
  } cfg_t;

endpackage

// ===== hdl/tsw_cfg_regs.sv =====
// configuration register file of the texture tile swizzle unit
// depends on tsw_pkg
module tsw_cfg_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tsw_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  output tsw_pkg::cfg_t                      cfg_o
);

  tsw_pkg::cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsw_pkg::REG_FORMAT: cfg_d.format_code  = cfg_wdata_i[tsw_pkg::FMT_W-1:0];
        tsw_pkg::REG_WIDTH:  cfg_d.image_width  = cfg_wdata_i[tsw_pkg::DIM_REG_W-1:0];
        tsw_pkg::REG_HEIGHT: cfg_d.image_height = cfg_wdata_i[tsw_pkg::DIM_REG_W-1:0];
        tsw_pkg::REG_SWAP:   cfg_d.endian_swap  = cfg_wdata_i[0];
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.format_code  <= tsw_pkg::FORMAT_RST;
      cfg_q.image_width  <= tsw_pkg::DIM_RST;
      cfg_q.image_height <= tsw_pkg::DIM_RST;
      cfg_q.endian_swap  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hdl/tsw_map.sv =====
// tile address and write data mapping for one pixel and one result phase
// depends on tsw_pkg; purely combinational
module tsw_map #(
  parameter int MAX_DIM = tsw_pkg::MAX_DIM_DEF
) (
  input  tsw_pkg::cfg_t      cfg_i,
  input  tsw_pkg::pixel_in_t pix_i,
  input  logic               phase_i,
  output logic               no_result_o,
  output tsw_pkg::result_t   res_o
);

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int CW     = (DIM_W > tsw_pkg::DIM_REG_W) ? DIM_W : tsw_pkg::DIM_REG_W;
  localparam int TILE_W = CW - 1;
  localparam int ROW_W  = tsw_pkg::PIX_W - 2;
  localparam int PW     = ROW_W + TILE_W + 1;
  localparam int OW     = PW + 6;

  logic [CW-1:0]       w_ext, h_ext, w_cl, h_cl;
  logic [CW:0]         w_p4, w_p8;
  logic [TILE_W-1:0]   tiles4, tiles8, tiles_sel;
  logic [ROW_W-1:0]    x_tile;
  logic [ROW_W+TILE_W-1:0] prod;
  logic [PW-1:0]       tile;
  logic [OW-1:0]       off_full;
  logic                is_rgba, is_8bit, outside;
  logic [7:0]          b0, b1, b2, b3;
  logic [tsw_pkg::PIX_W-1:0] px, py;

  assign px = pix_i.pixel_x;
  assign py = pix_i.pixel_y;
  assign b0 = pix_i.pixel_value[7:0];
  assign b1 = pix_i.pixel_value[15:8];
  assign b2 = pix_i.pixel_value[23:16];
  assign b3 = pix_i.pixel_value[31:24];

  // format classes
  assign no_result_o = (cfg_i.format_code == tsw_pkg::FMT_I4);
  assign is_rgba     = (cfg_i.format_code == tsw_pkg::FMT_RGBA8);
  assign is_8bit     = (cfg_i.format_code == tsw_pkg::FMT_I8)
                    || (cfg_i.format_code == tsw_pkg::FMT_IA4)
                    || (cfg_i.format_code == tsw_pkg::FMT_C8);

  // dimensions clamped to the largest supported size
  assign w_ext = CW'(cfg_i.image_width);
  assign h_ext = CW'(cfg_i.image_height);
  assign w_cl  = (w_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : w_ext;
  assign h_cl  = (h_ext > CW'(MAX_DIM)) ? CW'(MAX_DIM) : h_ext;
  assign outside = (CW'(px) >= w_cl) || (CW'(py) >= h_cl);

  // tiles per tile row, rounded up
  assign w_p4   = {1'b0, w_cl} + (CW+1)'(3);
  assign w_p8   = {1'b0, w_cl} + (CW+1)'(7);
  assign tiles4 = w_p4[CW:2];
  assign tiles8 = TILE_W'(w_p8[CW:3]);

  // tile index: one shared multiply for all formats
  assign tiles_sel = is_8bit ? tiles8 : tiles4;
  assign x_tile    = is_8bit ? {1'b0, px[tsw_pkg::PIX_W-1:3]} : px[tsw_pkg::PIX_W-1:2];
  assign prod      = (ROW_W+TILE_W)'(py[tsw_pkg::PIX_W-1:2])
                   * (ROW_W+TILE_W)'(tiles_sel);
  assign tile      = PW'(prod) + PW'(x_tile);

  // byte offset inside the buffer; slot bits sit below the tile base
  always_comb begin
    priority if (is_rgba) begin
      off_full = {tile, phase_i, py[1:0], px[1:0], 1'b0};
    end else if (is_8bit) begin
      off_full = {1'b0, tile, py[1:0], px[2:0]};
    end else begin
      off_full = {1'b0, tile, py[1:0], px[1:0], 1'b0};
    end
  end

  // result fields
  always_comb begin
    res_o = '0;
    priority if (outside) begin
      res_o.coord_error = 1'b1;
      res_o.last        = 1'b1;
    end else if (is_rgba) begin
      res_o.byte_offset = off_full[tsw_pkg::OFF_W-1:0];
      res_o.write_data  = phase_i ? {b1, b2} : {b3, b0};
      res_o.is_halfword = 1'b1;
      res_o.last        = phase_i;
    end else if (is_8bit) begin
      res_o.byte_offset = off_full[tsw_pkg::OFF_W-1:0];
      res_o.write_data  = {8'h00, b0};
      res_o.last        = 1'b1;
    end else begin
      res_o.byte_offset = off_full[tsw_pkg::OFF_W-1:0];
      res_o.write_data  = cfg_i.endian_swap ? {b0, b1} : {b1, b0};
      res_o.is_halfword = 1'b1;
      res_o.last        = 1'b1;
    end
  end

endmodule

// ===== hdl/texture_tile_swizzle_unit.sv =====
// Texture tile swizzle unit: maps linear-image pixels to tiled buffer writes.
// Request channel in_valid_i/in_ready_o carries one pixel (x, y, value);
// result channel out_valid_o/out_ready_i carries one write (offset, data,
// size, coordinate error, last). Both are valid/ready, taken when both high.
// Configuration goes through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must
// write it only while no request is in flight; the block does not enforce it.
// A taken request is held in the input register, and its result is then
// registered in the result register.
// Throughput: one request per cycle for 8-bit and 16-bit formats while the
// receiver does not stall; each RGBA8 request yields two halfword results
// through the single result register. A 4-bit request is consumed silently.
// A coordinate outside the image yields one flagged result with no write.
// Reset clears both stages and loads format 0, a 4x4 image and no swap.
// When the receiver stalls, the result register holds; one more request
// waits in the input register and the request channel then drops ready.
// Depends on tsw_pkg, tsw_cfg_regs and tsw_map.
module texture_tile_swizzle_unit #(
  parameter int MAX_DIM = tsw_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tsw_pkg::pixel_in_t             in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tsw_pkg::result_t               out_res_o,
  input  logic                           cfg_we_i,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsw_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  tsw_pkg::cfg_t      cfg;
  tsw_pkg::pixel_in_t s1_q, s1_d;
  tsw_pkg::result_t   res, out_q, out_d;
  logic               s1_valid_q, s1_valid_d;
  logic               phase_q, phase_d;
  logic               out_valid_q, out_valid_d;
  logic               no_result, has_res, out_free, out_load, s1_release, in_take;

  tsw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tsw_map #(
    .MAX_DIM (MAX_DIM)
  ) u_map (
    .cfg_i       (cfg),
    .pix_i       (s1_q),
    .phase_i     (phase_q),
    .no_result_o (no_result),
    .res_o       (res)
  );

  // stage handshakes
  assign has_res    = s1_valid_q && !no_result;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = has_res && out_free;
  assign s1_release = s1_valid_q && (no_result || (out_load && res.last));
  assign in_ready_o = !s1_valid_q || s1_release;
  assign in_take    = in_valid_i && in_ready_o;

  // input register and result phase
  always_comb begin
    s1_d       = in_take ? in_req_i : s1_q;
    s1_valid_d = in_take || (s1_valid_q && !s1_release);
    phase_d    = phase_q;
    if (out_load && !res.last) begin
      phase_d = 1'b1;
    end else if (s1_release) begin
      phase_d = 1'b0;
    end
  end

  // result register
  always_comb begin
    out_d       = out_load ? res : out_q;
    out_valid_d = out_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q  <= s1_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

// ===== hdl/tsw_checker.sv =====
// port-level checks of the texture tile swizzle unit, bound to the top level
// depends on tsw_pkg and texture_tile_swizzle_unit_assert.svh
`include "texture_tile_swizzle_unit_assert.svh"

module tsw_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input tsw_pkg::result_t out_res_o
);

  // a stalled result stays offered
  `TSW_ASSERT(a_out_keep, out_valid_o && !out_ready_i |=> out_valid_o, "result dropped while stalled")

  // a stalled result holds its fields
  `TSW_ASSERT_STABLE(a_out_hold, out_valid_o && !out_ready_i, out_res_o, "result changed while stalled")

  // coordinate errors carry no write and end the request
  `TSW_ASSERT(a_err_clean, out_valid_o && out_res_o.coord_error |-> out_res_o.last && !out_res_o.is_halfword && out_res_o.byte_offset == '0 && out_res_o.write_data == '0, "error result not clean")

  // byte writes keep the upper data byte zero
  `TSW_ASSERT(a_byte_data, out_valid_o && !out_res_o.is_halfword |-> out_res_o.write_data[15:8] == 8'h00, "byte write with upper data")

  // only the alpha-red half of an RGBA8 pixel is a non-final result
  `TSW_ASSERT(a_first_half, out_valid_o && !out_res_o.last |-> out_res_o.is_halfword && !out_res_o.coord_error && !out_res_o.byte_offset[5], "bad non-final result")

endmodule

bind texture_tile_swizzle_unit tsw_checker u_tsw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

// ===== dv/tile_write_checker.sv =====
// checker for the texture tile swizzle unit: mirrors the registers, predicts
// the tiled writes of every accepted request and compares results in order
// depends on tsw_pkg
module tile_write_checker #(
  parameter int MAX_DIM = tsw_pkg::MAX_DIM_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  tsw_pkg::pixel_in_t             in_req_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  tsw_pkg::result_t               out_res_i,
  input  logic                           cfg_we_i,
  input  logic [tsw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tsw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    writes_due_o,
  output int unsigned                    fail_count_o
);
  import tsw_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  // mirrored registers
  logic [FMT_W-1:0]     fmt_q;
  logic [DIM_REG_W-1:0] width_q;
  logic [DIM_REG_W-1:0] height_q;
  logic                 swap_q;

  // writes still owed by the unit, oldest first
  result_t writes_due[$];

  function automatic void note_failure(input string msg);
    fail_count_o++;
    if (fail_count_o <= REPORT_MAX) $display("%s", msg);
  endfunction

  function automatic void owe_write(input logic [31:0] off, input logic [15:0] data,
                                    input logic half, input logic err, input logic fin);
    result_t r;
    r.byte_offset = off[OFF_W-1:0];
    r.write_data  = data;
    r.is_halfword = half;
    r.coord_error = err;
    r.last        = fin;
    writes_due.push_back(r);
  endfunction

  // tiled writes of one pixel under the current registers
  function automatic void predict_tile_writes(input pixel_in_t px);
    logic [31:0] w;
    logic [31:0] h;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] tiles;
    logic [31:0] tile;
    logic [31:0] off;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    // oversized dimensions are clamped for range test and addressing
    w = (32'(width_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(width_q);
    h = (32'(height_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(height_q);
    x = 32'(px.pixel_x);
    y = 32'(px.pixel_y);
    {b3, b2, b1, b0} = px.pixel_value;
    // 4-bit format has no write path
    if (fmt_q == FMT_I4) return;
    if (x >= w || y >= h) begin
      owe_write('0, '0, 1'b0, 1'b1, 1'b1);
      return;
    end
    if (fmt_q == FMT_RGBA8) begin
      // 4x4 tiles of 64 bytes, ar half then gb half
      tiles = (w + 3) >> 2;
      tile  = (y >> 2) * tiles + (x >> 2);
      off   = tile * 64 + (y & 3) * 8 + (x & 3) * 2;
      owe_write(off, {b3, b0}, 1'b1, 1'b0, 1'b0);
      owe_write(off + 32, {b1, b2}, 1'b1, 1'b0, 1'b1);
    end else if (fmt_q == FMT_I8 || fmt_q == FMT_IA4 || fmt_q == FMT_C8) begin
      // 8x4 tiles of 32 bytes
      tiles = (w + 7) >> 3;
      tile  = (y >> 2) * tiles + (x >> 3);
      off   = tile * 32 + (y & 3) * 8 + (x & 7);
      owe_write(off, {8'h00, b0}, 1'b0, 1'b0, 1'b1);
    end else begin
      // 16-bit: 4x4 tiles of 32 bytes
      tiles = (w + 3) >> 2;
      tile  = (y >> 2) * tiles + (x >> 2);
      off   = tile * 32 + (((y & 3) * 4 + (x & 3)) << 1);
      owe_write(off, swap_q ? {b0, b1} : {b1, b0}, 1'b1, 1'b0, 1'b1);
    end
  endfunction

  // monitor both channels and the register port
  always @(posedge clk_i or negedge rst_ni) begin
    result_t due;
    if (!rst_ni) begin
      fmt_q    = FORMAT_RST;
      width_q  = DIM_RST;
      height_q = DIM_RST;
      swap_q   = 1'b0;
      writes_due.delete();
    end else begin
      // compare a taken result with the oldest owed write
      if (out_valid_i && out_ready_i) begin
        if (writes_due.size() == 0) begin
          note_failure($sformatf("unexpected result off=%h data=%h half=%b err=%b last=%b",
                                 out_res_i.byte_offset, out_res_i.write_data,
                                 out_res_i.is_halfword, out_res_i.coord_error,
                                 out_res_i.last));
        end else begin
          due = writes_due.pop_front();
          if (out_res_i.byte_offset !== due.byte_offset ||
              out_res_i.write_data !== due.write_data ||
              out_res_i.is_halfword !== due.is_halfword ||
              out_res_i.coord_error !== due.coord_error ||
              out_res_i.last !== due.last) begin
            note_failure($sformatf({"mismatch exp off=%h data=%h half=%b err=%b last=%b",
                                    " got off=%h data=%h half=%b err=%b last=%b"},
                                   due.byte_offset, due.write_data, due.is_halfword,
                                   due.coord_error, due.last,
                                   out_res_i.byte_offset, out_res_i.write_data,
                                   out_res_i.is_halfword, out_res_i.coord_error,
                                   out_res_i.last));
          end
        end
      end
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FORMAT: fmt_q    = cfg_wdata_i[FMT_W-1:0];
          REG_WIDTH:  width_q  = cfg_wdata_i[DIM_REG_W-1:0];
          REG_HEIGHT: height_q = cfg_wdata_i[DIM_REG_W-1:0];
          REG_SWAP:   swap_q   = cfg_wdata_i[0];
          default: ;
        endcase
      end
      // new request
      if (in_valid_i && in_ready_i) predict_tile_writes(in_req_i);
    end
    writes_due_o = writes_due.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// testbench top for the texture tile swizzle unit: clock, reset, register
// setup, pixel requests, receiver stalls and the final verdict
// depends on tsw_pkg, tile_write_checker and texture_tile_swizzle_unit
module tb_top;
  import tsw_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned RANDOM_PHASES   = 14;
  localparam int unsigned ITEMS_PER_PHASE = 50;
  localparam int unsigned I4_ITEMS        = 10;

  // 16-bit format codes outside the named formats
  localparam logic [FMT_W-1:0] FMT_HALF_LOW = 4'd1;
  localparam logic [FMT_W-1:0] FMT_HALF_TOP = 4'd15;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pixel_in_t             in_req    = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  result_t               out_res;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = REG_FORMAT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned writes_due;
  int unsigned fail_count;
  int unsigned cycle_count        = 0;
  int unsigned sender_gap_pct     = 33;
  int unsigned receiver_stall_pct = 72;

  // image size in force, for picking coordinates
  logic [DIM_REG_W-1:0] cur_width  = DIM_RST;
  logic [DIM_REG_W-1:0] cur_height = DIM_RST;

  texture_tile_swizzle_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_res_o   (out_res),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  tile_write_checker write_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_res_i    (out_res),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .writes_due_o (writes_due),
    .fail_count_o (fail_count)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // cycle count and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk);
    $display("tb_top: FAIL");
    $finish;
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(99) >= receiver_stall_pct);
  end

  // one pixel request, with a random gap in front
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y,
                            input logic [VALUE_W-1:0] v);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= '{pixel_x: x, pixel_y: y, pixel_value: v};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every owed write has come and the pipe has emptied
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (writes_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers back to back while idle
  task automatic load_config(input logic [FMT_W-1:0] fmt, input logic [DIM_REG_W-1:0] wd,
                             input logic [DIM_REG_W-1:0] ht, input logic sw);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_FORMAT;
    cfg_wdata <= CFG_DATA_W'(fmt);
    @(posedge clk);
    cfg_idx   <= REG_WIDTH;
    cfg_wdata <= CFG_DATA_W'(wd);
    @(posedge clk);
    cfg_idx   <= REG_HEIGHT;
    cfg_wdata <= CFG_DATA_W'(ht);
    @(posedge clk);
    cfg_idx   <= REG_SWAP;
    cfg_wdata <= CFG_DATA_W'(sw);
    @(posedge clk);
    cfg_we     <= 1'b0;
    cur_width  = wd;
    cur_height = ht;
  endtask

  // image dimension: mostly tile multiples, some ragged, zero or oversized
  function automatic logic [DIM_REG_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return DIM_REG_W'($urandom());
      1:       return DIM_REG_W'(MAX_DIM_DEF);
      2, 3:    return DIM_REG_W'($urandom_range(1, 256));
      default: return DIM_REG_W'($urandom_range(1, 32) * 8);
    endcase
  endfunction

  // coordinate mostly inside the image, sometimes anywhere
  function automatic logic [PIX_W-1:0] pick_coord(input logic [DIM_REG_W-1:0] dim);
    int unsigned lim;
    lim = (dim > MAX_DIM_DEF) ? MAX_DIM_DEF : dim;
    if (lim == 0 || $urandom_range(9) == 0) return PIX_W'($urandom());
    return PIX_W'($urandom_range(lim - 1));
  endfunction

  // random register setting followed by random pixels
  task automatic run_random_phase(input int unsigned idx);
    logic [FMT_W-1:0] fmt;
    int unsigned      count;
    if (idx % 2 == 0) begin
      fmt = FMT_W'($urandom());
    end else begin
      case ($urandom_range(3))
        0:       fmt = FMT_RGBA8;
        1:       fmt = FMT_I8;
        2:       fmt = FMT_IA4;
        default: fmt = FMT_C8;
      endcase
    end
    load_config(fmt, pick_dim(), pick_dim(), 1'($urandom_range(1)));
    // 4-bit requests produce nothing, keep them few
    count = (fmt == FMT_I4) ? I4_ITEMS : ITEMS_PER_PHASE;
    repeat (count) send_pixel(pick_coord(cur_width), pick_coord(cur_height), $urandom());
  endtask

  // stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: 16-bit, 4x4, no swap
    send_pixel(10'd0, 10'd0, 32'h0000_0000);
    send_pixel(10'd3, 10'd3, 32'hffff_ffff);
    send_pixel(10'd4, 10'd0, 32'h1234_5678);
    send_pixel(10'd0, 10'd4, 32'h8765_4321);
    send_pixel(10'd1023, 10'd1023, 32'hdead_beef);

    // rgba8 at full size, both corners
    load_config(FMT_RGBA8, 11'd1024, 11'd1024, 1'b0);
    send_pixel(10'd0, 10'd0, 32'h1122_3344);
    send_pixel(10'd1023, 10'd1023, 32'ha5a5_5a5a);
    send_pixel(10'd5, 10'd6, 32'hc3c3_3c3c);

    // 8-bit with swap set, edge and just outside
    load_config(FMT_I8, 11'd16, 11'd8, 1'b1);
    send_pixel(10'd15, 10'd7, 32'hffff_ff81);
    send_pixel(10'd16, 10'd0, 32'h0000_0042);
    send_pixel(10'd7, 10'd3, 32'h0102_0304);

    // ragged width, tiles per row round up
    load_config(FMT_IA4, 11'd13, 11'd12, 1'b0);
    send_pixel(10'd12, 10'd11, 32'h5555_aaaa);
    send_pixel(10'd13, 10'd0, 32'haaaa_5555);

    // oversized dimensions clamp to the maximum
    load_config(FMT_C8, 11'd2047, 11'd2047, 1'b0);
    send_pixel(10'd1023, 10'd1023, 32'h0f0f_f0f0);
    send_pixel(10'd1023, 10'd0, 32'hf0f0_0f0f);

    // zero-sized image, top format code
    load_config(FMT_HALF_TOP, 11'd0, 11'd0, 1'b1);
    send_pixel(10'd0, 10'd0, 32'h1357_9bdf);

    // 4-bit format yields nothing
    load_config(FMT_I4, 11'd64, 11'd64, 1'b0);
    send_pixel(10'd0, 10'd0, 32'h2468_ace0);
    send_pixel(10'd1023, 10'd1023, 32'hffff_ffff);

    // 16-bit with byte swap
    load_config(FMT_HALF_LOW, 11'd1024, 11'd4, 1'b1);
    send_pixel(10'd1023, 10'd3, 32'h0000_abcd);
    send_pixel(10'd0, 10'd4, 32'h0000_1234);

    // random phases with changing stall patterns
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 5) begin
        sender_gap_pct     = 72;
        receiver_stall_pct <= 33;
      end
      if (p == 10) begin
        sender_gap_pct     = 0;
        receiver_stall_pct <= 0;
      end
      run_random_phase(p);
    end

    settle();
    @(negedge clk);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/tsw_pkg.sv
hdl/tsw_cfg_regs.sv
hdl/tsw_map.sv
hdl/texture_tile_swizzle_unit.sv
hdl/tsw_checker.sv
dv/tile_write_checker.sv
dv/tb_top.sv
